### rtl/srgh_pkg.sv
package srgh_pkg;

    localparam int unsigned FifoDepth = 4;
    localparam int unsigned QuoBits   = 26;

    localparam logic [3:0] RegCamPosX  = 4'd0;
    localparam logic [3:0] RegCamPosY  = 4'd1;
    localparam logic [3:0] RegCamPosZ  = 4'd2;
    localparam logic [3:0] RegFrontVec = 4'd3;
    localparam logic [3:0] RegLeftVec  = 4'd4;
    localparam logic [3:0] RegUpVec    = 4'd5;
    localparam logic [3:0] RegFocal    = 4'd6;
    localparam logic [3:0] RegAspect   = 4'd7;

    localparam logic [23:0] FarPoint = 24'd256000;
    localparam logic [23:0] PosMax   = 24'h7FFFFF;
    localparam logic [23:0] PosMin   = 24'h800000;

    typedef struct packed {
        logic [23:0] pos_x;
        logic [23:0] pos_y;
        logic [23:0] pos_z;
        logic [47:0] front;
        logic [47:0] left;
        logic [47:0] up;
        logic [15:0] focal;
        logic [15:0] aspect;
    } t_cfg;

    typedef struct packed {
        logic [52:0] vx;
        logic [52:0] vy;
        logic [52:0] vz;
        logic [24:0] dh;
        logic [23:0] h;
    } t_fq;

    typedef struct packed {
        logic        ovf;
        logic [52:0] rem;
        logic [QuoBits-1:0] num;
        logic [QuoBits-1:0] quo;
    } t_lane;

    typedef struct packed {
        logic        par;
        logic        negx;
        logic        negz;
        logic [23:0] h;
        logic [52:0] den;
        t_lane       lx;
        t_lane       lz;
    } t_bk;

    typedef struct packed {
        logic [23:0] hit_x;
        logic [23:0] hit_y;
        logic [23:0] hit_z;
        logic        ray_parallel;
        logic        saturated;
    } t_res;

endpackage

### rtl/screen_ray_ground_hit.sv
// Intersects a picking ray through a normalized screen point with the horizontal plane at
// the item's ground height, for a camera set up through the configuration registers. One
// item is accepted per cycle unless a full queue stalls the front stages, and results come
// out in order: three stages form the ray direction, a four-entry queue follows, and the
// back end spends most of its stages in a 26-stage restoring divider that produces one
// quotient bit per stage.
module screen_ray_ground_hit import srgh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // norm_x[16:0], norm_y[33:17], ground_height[57:34]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,  // hit_x[23:0], hit_y[47:24], hit_z[71:48]
    output logic [1:0]  m_axis_tuser   // ray_parallel[0], saturated[1]
);

    t_cfg r_cfg;
    t_fq  f_data, q_data;
    logic f_push, q_full, q_empty, q_pop;
    t_res res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{pos_x: '0, pos_y: '0, pos_z: '0, front: '0, left: '0, up: '0,
                       focal: 16'd7094, aspect: 16'd4096};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                RegCamPosX:  r_cfg.pos_x  <= i_cfg_data[23:0];
                RegCamPosY:  r_cfg.pos_y  <= i_cfg_data[23:0];
                RegCamPosZ:  r_cfg.pos_z  <= i_cfg_data[23:0];
                RegFrontVec: r_cfg.front  <= i_cfg_data;
                RegLeftVec:  r_cfg.left   <= i_cfg_data;
                RegUpVec:    r_cfg.up     <= i_cfg_data;
                RegFocal:    r_cfg.focal  <= i_cfg_data[15:0];
                RegAspect:   r_cfg.aspect <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    srgh_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_norm_x(s_axis_tdata[16:0]), .i_norm_y(s_axis_tdata[33:17]),
        .i_ground_height(s_axis_tdata[57:34]),
        .o_push(f_push), .o_data(f_data), .i_full(q_full)
    );

    srgh_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(f_push), .i_data(f_data),
        .i_pop(q_pop), .o_data(q_data), .o_full(q_full), .o_empty(q_empty)
    );

    srgh_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg), .i_data(q_data),
        .i_empty(q_empty), .o_pop(q_pop), .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready), .o_res(res)
    );

    assign m_axis_tdata = {res.hit_z, res.hit_y, res.hit_x};
    assign m_axis_tuser = {res.saturated, res.ray_parallel};

endmodule

### rtl/srgh_front.sv
module srgh_front import srgh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [16:0] i_norm_x,
    input  logic [16:0] i_norm_y,
    input  logic [23:0] i_ground_height,
    output logic        o_push,
    output t_fq         o_data,
    input  logic        i_full
);

    logic [2:0]  r_v;
    logic        en;
    logic [18:0] x, y;
    logic [32:0] r_pf  [3];
    logic [34:0] r_pl  [3];
    logic [34:0] r_pu  [3];
    logic [32:0] r_pf2 [3];
    logic [34:0] r_pu2 [3];
    logic [51:0] r_pla [3];
    logic [24:0] r_dh1, r_dh2;
    logic [23:0] r_h1, r_h2;
    logic [52:0] r_v3  [3];
    logic [24:0] r_dh3;
    logic [23:0] r_h3;

    assign en      = !r_v[2] || !i_full;
    assign o_ready = en;
    assign o_push  = r_v[2] && !i_full;
    assign x = 19'd65536 - {1'b0, i_norm_x, 1'b0};
    assign y = {1'b0, i_norm_y, 1'b0} - 19'd65536;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                r_pf[c] <= 33'($signed(i_cfg.front[16*c +: 16]) * $signed({1'b0, i_cfg.focal}));
                r_pl[c] <= 35'($signed(i_cfg.left[16*c +: 16]) * $signed(x));
                r_pu[c] <= 35'($signed(i_cfg.up[16*c +: 16]) * $signed(y));
                r_pf2[c] <= r_pf[c];
                r_pu2[c] <= r_pu[c];
                r_pla[c] <= 52'($signed(r_pl[c]) * $signed({1'b0, i_cfg.aspect}));
                r_v3[c] <= $signed({{4{r_pf2[c][32]}}, r_pf2[c], 16'b0})
                         + $signed({r_pla[c][51], r_pla[c]})
                         - $signed({{6{r_pu2[c][34]}}, r_pu2[c], 12'b0});
            end
            r_dh1 <= $signed({i_ground_height[23], i_ground_height})
                   - $signed({i_cfg.pos_y[23], i_cfg.pos_y});
            r_h1  <= i_ground_height;
            r_dh2 <= r_dh1;
            r_h2  <= r_h1;
            r_dh3 <= r_dh2;
            r_h3  <= r_h2;
        end
    end

    assign o_data = '{vx: r_v3[0], vy: r_v3[1], vz: r_v3[2], dh: r_dh3, h: r_h3};

endmodule

### rtl/srgh_fifo.sv
module srgh_fifo import srgh_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_fq  i_data,
    input  logic i_pop,
    output t_fq  o_data,
    output logic o_full,
    output logic o_empty
);

    localparam int unsigned Aw = $clog2(FifoDepth);

    t_fq             r_mem [FifoDepth];
    logic [Aw-1:0]   r_wr, r_rd;
    logic [Aw:0]     r_cnt;

    assign o_full  = r_cnt == (Aw+1)'(FifoDepth);
    assign o_empty = r_cnt == '0;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop) r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (Aw+1)'(i_push) - (Aw+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

endmodule

### rtl/srgh_back.sv
module srgh_back import srgh_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  t_fq  i_data,
    input  logic i_empty,
    output logic o_pop,
    output logic o_valid,
    input  logic i_ready,
    output t_res o_res
);

    logic        en;
    logic        r_v0, r_v1;
    logic [QuoBits:0] r_v;
    logic [51:0] r_mx, r_mz, r_my;
    logic [24:0] r_mdh;
    logic        r_par0, r_nx0, r_nz0, r_par1, r_nx1, r_nz1;
    logic [23:0] r_h0, r_h1;
    logic [50:0] r_lox, r_hix, r_loz, r_hiz;
    logic [51:0] r_my1;
    t_bk         r_st [QuoBits+1];
    t_bk         s_init;
    logic [76:0] px, pz;
    logic [77:0] nx, nz;
    logic [52:0] den;
    t_res        r_out;
    logic        r_ov;
    logic        sat;
    logic [23:0] hx, hz;

    assign en      = !r_ov || i_ready;
    assign o_pop   = en && !i_empty;
    assign o_valid = r_ov;
    assign o_res   = r_out;

    function automatic logic [51:0] mag53(input logic [52:0] v);
        logic [52:0] m;
        m = v[52] ? (53'd0 - v) : v;
        return m[51:0];
    endfunction

    function automatic t_lane step(input t_lane l, input logic [52:0] d);
        t_lane      o;
        logic [53:0] t;
        logic        ge;
        t  = {l.rem, l.num[QuoBits-1]};
        ge = t >= {1'b0, d};
        o.ovf = l.ovf;
        o.rem = ge ? 53'(t - {1'b0, d}) : t[52:0];
        o.num = {l.num[QuoBits-2:0], 1'b0};
        o.quo = {l.quo[QuoBits-2:0], ge};
        return o;
    endfunction

    function automatic t_bk advance(input t_bk b);
        t_bk o;
        o    = b;
        o.lx = step(b.lx, b.den);
        o.lz = step(b.lz, b.den);
        return o;
    endfunction

    function automatic logic [23:0] fin(input t_lane l, input logic neg,
                                        input logic [23:0] pos, output logic s);
        logic [QuoBits-1:0] q;
        logic [QuoBits+1:0] sq, sum;
        q   = l.ovf ? '1 : l.quo;
        sq  = neg ? ((QuoBits+2)'(0) - {2'b0, q}) : {2'b0, q};
        sum = {{(QuoBits-22){pos[23]}}, pos} + sq;
        s = 1'b0;
        if (!sum[QuoBits+1] && sum[QuoBits:23] != '0) begin
            s = 1'b1;
            return PosMax;
        end
        if (sum[QuoBits+1] && sum[QuoBits:23] != '1) begin
            s = 1'b1;
            return PosMin;
        end
        return sum[23:0];
    endfunction

    always_comb begin
        px  = {r_hix, 26'b0} + {26'b0, r_lox};
        pz  = {r_hiz, 26'b0} + {26'b0, r_loz};
        nx  = {px, 1'b0} + {26'b0, r_my1};
        nz  = {pz, 1'b0} + {26'b0, r_my1};
        den = {r_my1, 1'b0};
        s_init.par  = r_par1;
        s_init.negx = r_nx1;
        s_init.negz = r_nz1;
        s_init.h    = r_h1;
        s_init.den  = den;
        s_init.lx.ovf = {1'b0, nx[77:QuoBits]} >= den;
        s_init.lx.rem = {1'b0, nx[77:QuoBits]};
        s_init.lx.num = nx[QuoBits-1:0];
        s_init.lx.quo = '0;
        s_init.lz.ovf = {1'b0, nz[77:QuoBits]} >= den;
        s_init.lz.rem = {1'b0, nz[77:QuoBits]};
        s_init.lz.num = nz[QuoBits-1:0];
        s_init.lz.quo = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v0 <= !i_empty;
            r_v1 <= r_v0;
            r_v  <= {r_v[QuoBits-1:0], r_v1};
            r_ov <= r_v[QuoBits];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mx   <= mag53(i_data.vx);
            r_my   <= mag53(i_data.vy);
            r_mz   <= mag53(i_data.vz);
            r_mdh  <= i_data.dh[24] ? (25'd0 - i_data.dh) : i_data.dh;
            r_par0 <= i_data.vy == '0;
            r_nx0  <= i_data.vx[52] ^ i_data.dh[24] ^ i_data.vy[52];
            r_nz0  <= i_data.vz[52] ^ i_data.dh[24] ^ i_data.vy[52];
            r_h0   <= i_data.h;

            r_lox  <= r_mx[25:0] * r_mdh;
            r_hix  <= r_mx[51:26] * r_mdh;
            r_loz  <= r_mz[25:0] * r_mdh;
            r_hiz  <= r_mz[51:26] * r_mdh;
            r_my1  <= r_my;
            r_par1 <= r_par0;
            r_nx1  <= r_nx0;
            r_nz1  <= r_nz0;
            r_h1   <= r_h0;

            r_st[0] <= s_init;
            for (int k = 1; k <= QuoBits; k++) begin
                r_st[k] <= advance(r_st[k-1]);
            end

            r_out <= '{hit_x: hx, hit_y: r_st[QuoBits].h, hit_z: hz,
                       ray_parallel: r_st[QuoBits].par, saturated: sat};
        end
    end

    always_comb begin
        logic sx, sz;
        hx = fin(r_st[QuoBits].lx, r_st[QuoBits].negx, i_cfg.pos_x, sx);
        hz = fin(r_st[QuoBits].lz, r_st[QuoBits].negz, i_cfg.pos_z, sz);
        sat = sx || sz;
        if (r_st[QuoBits].par) begin
            hx  = FarPoint;
            hz  = FarPoint;
            sat = 1'b0;
        end
    end

endmodule

### rtl/srgh_chk.sv
module srgh_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    a_rst_clear: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_far: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[23:0] == 24'd256000
        && m_axis_tdata[71:48] == 24'd256000 && !m_axis_tuser[1])
        else $error("parallel ray without far point");

    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
        m_axis_tdata[23:0] == 24'h7FFFFF || m_axis_tdata[23:0] == 24'h800000 ||
        m_axis_tdata[71:48] == 24'h7FFFFF || m_axis_tdata[71:48] == 24'h800000)
        else $error("saturation flag without clamped coordinate");

endmodule

bind screen_ray_ground_hit srgh_chk u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
);

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import srgh_pkg::*;

    class hit_scoreboard;
        longint cam[3];
        logic [47:0] axis[3];
        longint focal;
        longint aspect_q;
        t_res expected_hits[$];
        int errors;

        function new();
            cam[0] = 0;
            cam[1] = 0;
            cam[2] = 0;
            axis[0] = '0;
            axis[1] = '0;
            axis[2] = '0;
            focal = 7094;
            aspect_q = 4096;
            errors = 0;
        endfunction

        function void set_reg(logic [3:0] idx, logic [47:0] d);
            case (idx)
                RegCamPosX: cam[0] = longint'($signed(d[23:0]));
                RegCamPosY: cam[1] = longint'($signed(d[23:0]));
                RegCamPosZ: cam[2] = longint'($signed(d[23:0]));
                RegFrontVec: axis[0] = d;
                RegLeftVec: axis[1] = d;
                RegUpVec: axis[2] = d;
                RegFocal: focal = longint'(d[15:0]);
                RegAspect: aspect_q = longint'(d[15:0]);
                default: ;
            endcase
        endfunction

        function longint axis_comp(int k, int c);
            logic [15:0] raw;
            raw = axis[k][16*c +: 16];
            return longint'($signed(raw));
        endfunction

        function logic [127:0] scaled_quotient(logic [63:0] a, logic [63:0] b,
                                               logic [63:0] den);
            logic [127:0] num;
            logic [127:0] dd;
            logic [127:0] full;
            logic [127:0] q;
            num = a;
            num = num * b;
            num = num * 2 + den;
            dd = den;
            full = num / (dd * 2);
            q = 0;
            for (int i = 127; i >= 0; i--) begin
                if (q >= 128'd1099511627776) begin
                    q = 128'd1099511627776;
                end else begin
                    q = q * 2 + full[i];
                end
            end
            return q;
        endfunction

        function void note(logic [16:0] nx, logic [16:0] ny, logic [23:0] h);
            longint x, y, hs, dh, t, s;
            longint v[3];
            logic [127:0] q;
            logic neg, sat;
            t_res e;
            x = 65536 - 2 * longint'(nx);
            y = 2 * longint'(ny) - 65536;
            hs = longint'($signed(h));
            for (int c = 0; c < 3; c++) begin
                v[c] = axis_comp(0, c) * focal * 65536 + axis_comp(1, c) * x * aspect_q
                     - axis_comp(2, c) * y * 4096;
            end
            e.hit_y = h;
            e.ray_parallel = (v[1] == 0);
            sat = 1'b0;
            if (e.ray_parallel) begin
                e.hit_x = FarPoint;
                e.hit_z = FarPoint;
            end else begin
                dh = hs - cam[1];
                for (int c = 0; c < 3; c += 2) begin
                    q = scaled_quotient(v[c] < 0 ? -v[c] : v[c], dh < 0 ? -dh : dh,
                                        v[1] < 0 ? -v[1] : v[1]);
                    neg = ((v[c] < 0) != (dh < 0)) != (v[1] < 0);
                    t = longint'(q[63:0]);
                    s = cam[c] + (neg ? -t : t);
                    if (s > 8388607) begin
                        s = 8388607;
                        sat = 1'b1;
                    end else if (s < -8388608) begin
                        s = -8388608;
                        sat = 1'b1;
                    end
                    if (c == 0) e.hit_x = s[23:0];
                    else e.hit_z = s[23:0];
                end
            end
            e.saturated = sat;
            expected_hits.push_back(e);
        endfunction

        task report(string what, logic [23:0] got, logic [23:0] want);
            $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
            errors++;
        endtask

        task check(t_res got);
            t_res e;
            if (expected_hits.size() == 0) begin
                report("unexpected item", got.hit_x, 24'h0);
            end else begin
                e = expected_hits.pop_front();
                if (got.hit_x !== e.hit_x) report("hit_x", got.hit_x, e.hit_x);
                if (got.hit_y !== e.hit_y) report("hit_y", got.hit_y, e.hit_y);
                if (got.hit_z !== e.hit_z) report("hit_z", got.hit_z, e.hit_z);
                if (got.ray_parallel !== e.ray_parallel)
                    report("ray_parallel", got.ray_parallel, e.ray_parallel);
                if (got.saturated !== e.saturated)
                    report("saturated", got.saturated, e.saturated);
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [3:0]  i_cfg_idx;
    logic [47:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    hit_scoreboard sb;
    int send_idle;
    int recv_idle;
    int hold_cycles;
    int quiet_cycles;

    screen_ray_ground_hit DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    always @(posedge i_clk) begin
        t_res got;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            sb.note(s_axis_tdata[16:0], s_axis_tdata[33:17], s_axis_tdata[57:34]);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.hit_x = m_axis_tdata[23:0];
            got.hit_y = m_axis_tdata[47:24];
            got.hit_z = m_axis_tdata[71:48];
            got.ray_parallel = m_axis_tuser[0];
            got.saturated = m_axis_tuser[1];
            sb.check(got);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles > 3000) begin
            $display("simulation failed");
            $finish;
        end
    end

    task cfg_write(logic [3:0] idx, logic [47:0] d);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        sb.set_reg(idx, d);
    endtask

    task wait_drain();
        while (sb.expected_hits.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task apply_cfg(logic [23:0] px, logic [23:0] py, logic [23:0] pz, logic [47:0] fr,
                   logic [47:0] lf, logic [47:0] up, logic [15:0] fo, logic [15:0] asp);
        s_axis_tvalid <= 1'b0;
        wait_drain();
        cfg_write(RegCamPosX, {24'h0, px});
        cfg_write(RegCamPosY, {24'h0, py});
        cfg_write(RegCamPosZ, {24'h0, pz});
        cfg_write(RegFrontVec, fr);
        cfg_write(RegLeftVec, lf);
        cfg_write(RegUpVec, up);
        cfg_write(RegFocal, {32'h0, fo});
        cfg_write(RegAspect, {32'h0, asp});
        cfg_write(4'($urandom_range(8, 15)), {$urandom, $urandom});
        i_cfg_we <= 1'b0;
    endtask

    task send_item(logic [16:0] nx, logic [16:0] ny, logic [23:0] h);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'h0, h, ny, nx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    function logic [16:0] pick_coord();
        int r;
        r = $urandom_range(99);
        if (r < 80) return 17'($urandom_range(0, 65536));
        if (r < 90) return 17'($urandom);
        case ($urandom_range(2))
            0: return 17'd0;
            1: return 17'd32768;
            default: return 17'd65536;
        endcase
    endfunction

    function logic [15:0] pick_comp();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($signed(16'($urandom_range(0, 32)) - 16'sd16));
            2: return 16'($urandom_range(0, 16384));
            default: return 16'($signed(-16'sd1) * 16'($urandom_range(0, 16384)));
        endcase
    endfunction

    task random_cfg();
        logic [23:0] p[3];
        logic [47:0] a[3];
        logic [15:0] fo, asp;
        for (int k = 0; k < 3; k++) begin
            p[k] = ($urandom_range(1) == 0) ? 24'($urandom)
                 : 24'($signed(24'($urandom_range(0, 16384)) - 24'sd8192));
            a[k] = {pick_comp(), pick_comp(), pick_comp()};
        end
        if ($urandom_range(4) == 0) a[0][31:16] = 16'h0;
        fo = ($urandom_range(30) == 0) ? 16'h0 : 16'($urandom_range(1, 65535));
        asp = ($urandom_range(30) == 0) ? 16'h0 : 16'($urandom_range(1, 65535));
        apply_cfg(p[0], p[1], p[2], a[0], a[1], a[2], fo, asp);
    endtask

    task random_items(int n);
        logic [23:0] h;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) < 7) begin
                h = 24'(sb.cam[1] + longint'($urandom_range(0, 8192)) - 4096);
            end else begin
                h = 24'($urandom);
            end
            send_item(pick_coord(), pick_coord(), h);
        end
    endtask

    initial begin
        sb = new();
        send_idle = 0;
        recv_idle = 0;
        hold_cycles = 0;
        quiet_cycles = 0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        m_axis_tready <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(17'd0, 17'd0, 24'h0);
        send_item(17'd65536, 17'd65536, 24'h7FFFFF);
        send_item(17'h1FFFF, 17'd32768, 24'h800000);

        apply_cfg(24'd0, 24'd2560, 24'hFFFB00, {16'd0, 16'hE000, 16'd0},
                  {16'd0, 16'd0, 16'd16384}, {16'd8192, 16'd14189, 16'd0},
                  16'd7094, 16'd7282);
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                send_item(17'(i * 32768), 17'(j * 32768), 24'h0);
            end
        end
        send_item(17'd32768, 17'd32768, 24'd2560);
        send_item(17'h1FFFF, 17'h1FFFF, 24'h800000);
        send_item(17'd0, 17'h1FFFF, 24'h7FFFFF);
        send_item(17'd12345, 17'd40000, 24'hFFFF00);

        apply_cfg(24'h7FFFFF, 24'h800000, 24'h7FFFFF, {3{16'h7FFF}},
                  {16'h8000, 16'h7FFF, 16'h8000}, {3{16'h8000}}, 16'hFFFF, 16'hFFFF);
        send_item(17'd0, 17'd65536, 24'h7FFFFF);
        send_item(17'd65536, 17'd0, 24'h800000);
        send_item(17'h1FFFF, 17'h1FFFF, 24'h7FFFFF);

        apply_cfg(24'h800000, 24'h7FFFFF, 24'h800000, {3{16'h8000}},
                  {3{16'h7FFF}}, {16'h7FFF, 16'h8000, 16'h7FFF}, 16'd1, 16'd1);
        send_item(17'd0, 17'd0, 24'h800000);
        send_item(17'd65536, 17'd65536, 24'h7FFFFF);

        apply_cfg(24'd256, 24'd1280, 24'd0, {16'd16384, 16'd0, 16'd0},
                  {16'd0, 16'd0, 16'd16384}, {16'd0, 16'd16384, 16'd0},
                  16'd4096, 16'd4096);
        send_item(17'd10000, 17'd32768, 24'd0);
        send_item(17'd10000, 17'd40000, 24'd0);
        send_item(17'd50000, 17'd20000, 24'd1280);

        for (int ph = 0; ph < 16; ph++) begin
            random_cfg();
            if (ph < 5) begin
                send_idle = 27;
                recv_idle = 76;
            end else if (ph < 10) begin
                send_idle = 76;
                recv_idle = 27;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            if (ph == 12) hold_cycles = 300;
            random_items(100);
        end
        s_axis_tvalid <= 1'b0;
        wait_drain();
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
